>>> hw/rtl/bdpc_pkg.sv
// Shared types and constants for the button debounce press classifier.
`default_nettype none

package bdpc_pkg;

    // Press classification codes
    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } t_event;

    // Register map indexes (byte address = 4 * index)
    localparam logic [1:0] REG_POLARITY_LOW    = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_LIMIT  = 2'd1;
    localparam logic [1:0] REG_LONG_HOLD_TICKS = 2'd2;

    // Reset values of the configuration registers
    localparam logic        RST_POLARITY_LOW    = 1'b1;
    localparam logic [7:0]  RST_DEBOUNCE_LIMIT  = 8'd3;
    localparam logic [31:0] RST_LONG_HOLD_TICKS = 32'd100;

    // Configuration as seen by the classifier core
    typedef struct packed {
        logic        polarity_low;
        logic [7:0]  debounce_limit;
        logic [31:0] long_hold_ticks;
    } t_cfg;

endpackage

`default_nettype wire

>>> hw/rtl/bdpc_cfg_regs.sv
// APB register bank holding polarity, debounce limit and long-hold time.
`default_nettype none

module bdpc_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output bdpc_pkg::t_cfg     o_cfg
);
    import bdpc_pkg::*;

    logic        r_polarity_low;
    logic [7:0]  r_debounce_limit;
    logic [31:0] r_long_hold_ticks;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity_low    <= RST_POLARITY_LOW;
            r_debounce_limit  <= RST_DEBOUNCE_LIMIT;
            r_long_hold_ticks <= RST_LONG_HOLD_TICKS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_POLARITY_LOW:    r_polarity_low    <= pwdata[0];
                REG_DEBOUNCE_LIMIT:  r_debounce_limit  <= pwdata[7:0];
                REG_LONG_HOLD_TICKS: r_long_hold_ticks <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_POLARITY_LOW:    prdata = {31'd0, r_polarity_low};
            REG_DEBOUNCE_LIMIT:  prdata = {24'd0, r_debounce_limit};
            REG_LONG_HOLD_TICKS: prdata = r_long_hold_ticks;
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{polarity_low:    r_polarity_low,
                     debounce_limit:  r_debounce_limit,
                     long_hold_ticks: r_long_hold_ticks};

endmodule

`default_nettype wire

>>> hw/rtl/bdpc_core.sv
// Debounce and press classification: input register, state update, result register.
`default_nettype none

module bdpc_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  bdpc_pkg::t_cfg      i_cfg,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic           i_pin_level,
    input  wire logic           i_apply_polarity,
    input  wire logic [31:0]    i_tick_now,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output bdpc_pkg::t_event    o_press_event
);
    import bdpc_pkg::*;

    // Input stage
    logic        r_in_valid;
    logic        r_pin_level;
    logic        r_apply;
    logic [31:0] r_tick;

    // Block state
    logic        r_stable_pressed;
    logic [7:0]  r_bounce_count;
    logic [31:0] r_press_time;
    logic        r_long_done;

    // Result stage
    logic        r_out_valid;
    t_event      r_event;

    logic        advance;
    logic        pressed;
    logic        differ;
    logic [7:0]  cnt_inc;
    logic        flip;
    logic        rise;
    logic        fall;
    logic [31:0] held_old;
    logic [31:0] held_new;
    logic        is_short;
    logic        is_long;
    logic        long_base;
    logic        n_stable_pressed;
    logic [7:0]  n_bounce_count;
    logic [31:0] n_press_time;
    logic        n_long_done;
    t_event      n_event;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_pin_level <= i_pin_level;
            r_apply     <= i_apply_polarity;
            r_tick      <= i_tick_now;
        end
    end

    // Debounce, then classify the press
    always_comb begin
        pressed  = (r_apply && i_cfg.polarity_low) ? !r_pin_level : r_pin_level;
        differ   = pressed != r_stable_pressed;
        cnt_inc  = r_bounce_count + 8'd1;
        flip     = differ && (cnt_inc >= i_cfg.debounce_limit);
        rise     = flip && pressed;
        fall     = flip && !pressed;

        n_bounce_count   = (differ && !flip) ? cnt_inc : 8'd0;
        n_stable_pressed = flip ? pressed : r_stable_pressed;
        n_press_time     = rise ? r_tick : r_press_time;

        held_old  = r_tick - r_press_time;
        held_new  = rise ? 32'd0 : held_old;
        long_base = rise ? 1'b0 : r_long_done;

        is_short = fall && !r_long_done && (held_old < i_cfg.long_hold_ticks);
        is_long  = !is_short && n_stable_pressed && !long_base
                   && (held_new >= i_cfg.long_hold_ticks);

        n_long_done = is_long ? 1'b1 : long_base;

        if (is_short) begin
            n_event = EVT_SHORT;
        end else if (is_long) begin
            n_event = EVT_LONG;
        end else begin
            n_event = EVT_NONE;
        end
    end

    // Update state as the item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_pressed <= 1'b0;
            r_bounce_count   <= 8'd0;
            r_press_time     <= 32'd0;
            r_long_done      <= 1'b0;
        end else if (advance) begin
            r_stable_pressed <= n_stable_pressed;
            r_bounce_count   <= n_bounce_count;
            r_press_time     <= n_press_time;
            r_long_done      <= n_long_done;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_event <= n_event;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_press_event = r_event;

    // A long report leaves the button held and the long flag set
    a_long_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (n_event == EVT_LONG) |=> r_long_done && r_stable_pressed)
        else $error("long press without held state");

    // A short report leaves the button released
    a_short_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (n_event == EVT_SHORT) |=> !r_stable_pressed)
        else $error("short press while still held");

    // The long flag only rises together with a long result
    a_long_flag_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_long_done) |-> r_out_valid && (r_event == EVT_LONG))
        else $error("long flag set without long result");

    // State holds while the result side stalls
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_stable_pressed) && $stable(r_long_done))
        else $error("state changed during output stall");

endmodule

`default_nettype wire

>>> hw/rtl/button_debounce_press_classifier_top.sv
// Top level: button debouncer with short and long press classification.
//
// Usage:
//   The slave stream carries one poll per item: tdata[0] is the pin level,
//   tdata[32:1] the free-running tick count, tuser[0] selects whether the
//   active-low polarity register is applied. Each poll produces exactly one
//   result item on the master stream: tdata[1:0] = 0 none, 1 short press,
//   2 long press.
//   An accepted poll is captured by the input register, and its event is
//   then taken by the result register once the master side can accept it.
//   Throughput is one poll per cycle while the master side does not stall;
//   the state update is a single compare-and-subtract step.
//   When the master side stalls, the result register holds and the input
//   register keeps one more poll; further polls see tready low.
//   The APB port at byte addresses 0, 4, 8 holds polarity_low,
//   debounce_limit and long_hold_ticks; write it only while no poll is in
//   flight. pready is always high.
//   Reset (synchronous, active low) empties both stages, clears the
//   debounce state and loads the register defaults 1, 3 and 100.
`default_nettype none

module button_debounce_press_classifier_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Poll stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [0] pin_level, [32:1] tick_now, [39:33] zero
    input  wire logic [0:0]  s_axis_tuser,  // [0] apply_polarity
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata   // [1:0] press_event, [7:2] zero
);
    import bdpc_pkg::*;

    t_cfg   cfg;
    t_event press_event;

    bdpc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bdpc_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_in_valid       (s_axis_tvalid),
        .o_in_ready       (s_axis_tready),
        .i_pin_level      (s_axis_tdata[0]),
        .i_apply_polarity (s_axis_tuser[0]),
        .i_tick_now       (s_axis_tdata[32:1]),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_press_event    (press_event)
    );

    assign m_axis_tdata = {6'd0, press_event};

endmodule

`default_nettype wire
